// ===== rtl/core/ctf_pkg.sv =====
package ctf_pkg;

  // Table size and defaults
  localparam int ATAN_ENTRIES     = 24;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int IDX_W            = $clog2(ATAN_ENTRIES);
  localparam int QUEUE_DEPTH      = 2;

  // Datapath widths
  localparam int XY_W   = 36;   // CORDIC x/y, inputs scaled by 2^16 plus gain headroom
  localparam int Z_W    = 27;   // CORDIC angle, signed Q11.16 degrees
  localparam int OFS_W  = 25;   // tilt offset register
  localparam int ANG_W  = 32;   // stored angle
  localparam int RAW_W  = 16;   // raw sensor samples
  localparam int KC_W   = 38;   // fusion coefficients (signed)
  localparam int ACC_W  = 64;   // fusion accumulator
  localparam int ATAN_W = 22;   // atan table entry

  localparam logic signed [Z_W-1:0]  DEG180   = 27'sd11796480;
  localparam logic signed [KC_W-1:0] K_KEEP   = 38'sd1052266988;
  localparam logic signed [KC_W-1:0] K_ACC    = 38'sd21474836;
  localparam logic signed [KC_W-1:0] K_GYRO   = 38'sd82595524923;
  localparam logic signed [ACC_W-1:0] HALF_Q30 = 64'sd536870912;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_FUSE,
    ST_DONE
  } ctf_state_t;

  // One classified request, front to back
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic signed [RAW_W-1:0] gx;
    logic                    bypass;   // angle is final, no rotation needed
  } ctf_req_t;

  // Back end control strobes
  typedef struct packed {
    logic pop;
    logic rot;
    logic fuse;
    logic finish;
  } ctf_ctl_t;

  // atan(2^-i) in unsigned Q6.16 degrees, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    v = '0;
    case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117266;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ctf_front.sv =====
module ctf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ctf_pkg::RAW_W-1:0]  in_acc_y,
  input  logic signed [ctf_pkg::RAW_W-1:0]  in_acc_z,
  input  logic signed [ctf_pkg::RAW_W-1:0]  in_gyro_x,
  output logic                              q_valid,
  output ctf_pkg::ctf_req_t                 q_req,
  input  logic                              q_pop
);

  localparam int PTR_W = (ctf_pkg::QUEUE_DEPTH > 1) ? $clog2(ctf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ctf_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(ctf_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ctf_pkg::QUEUE_DEPTH);

  ctf_pkg::ctf_req_t        queue_r [ctf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     push;
  ctf_pkg::ctf_req_t        cls;
  logic signed [ctf_pkg::XY_W-1:0] xs, ys;

  // Classify: scale by 2^16, mark x-axis samples as exact, turn other left half-plane vectors by 180 degrees
  always_comb begin
    xs = $signed({{(ctf_pkg::XY_W-ctf_pkg::RAW_W-16){in_acc_z[ctf_pkg::RAW_W-1]}},
                  in_acc_z, 16'b0});
    ys = $signed({{(ctf_pkg::XY_W-ctf_pkg::RAW_W-16){in_acc_y[ctf_pkg::RAW_W-1]}},
                  in_acc_y, 16'b0});
    cls.gx     = in_gyro_x;
    cls.bypass = 1'b0;
    cls.x      = xs;
    cls.y      = ys;
    cls.z      = '0;
    if (in_acc_y == '0) begin
      // on the x axis: result is exact
      cls.bypass = 1'b1;
      cls.z      = in_acc_z[ctf_pkg::RAW_W-1] ? ctf_pkg::DEG180 : '0;
    end else if (in_acc_z[ctf_pkg::RAW_W-1]) begin
      cls.x = -xs;
      cls.y = -ys;
      cls.z = in_acc_y[ctf_pkg::RAW_W-1] ? -ctf_pkg::DEG180 : ctf_pkg::DEG180;
    end
  end

  // Request queue
  assign in_stall = (count_r == CNT_FULL);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_req    = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

  // Pop only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("queue popped while empty");

endmodule

// ===== rtl/core/ctf_back.sv =====
module ctf_back #(
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  ctf_pkg::ctf_req_t                  q_req,
  output logic                               q_pop,
  input  logic signed [ctf_pkg::OFS_W-1:0]   tilt_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ctf_pkg::ANG_W-1:0]   out_fused_angle,
  output logic signed [ctf_pkg::Z_W-1:0]     out_accel_angle
);

  localparam int STEPS_EFF = (CORDIC_STEPS > ctf_pkg::ATAN_ENTRIES) ?
                             ctf_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam logic [ctf_pkg::IDX_W-1:0] ITER_LAST = ctf_pkg::IDX_W'(STEPS_EFF - 1);
  localparam int MUL_W = ctf_pkg::ANG_W + ctf_pkg::KC_W;

  ctf_pkg::ctf_state_t state_r, state_nxt;
  ctf_pkg::ctf_ctl_t   ctl;

  logic signed [ctf_pkg::XY_W-1:0]  x_r, y_r, dx, dy;
  logic signed [ctf_pkg::Z_W-1:0]   z_r, atan_s, acc_ang;
  logic signed [ctf_pkg::RAW_W-1:0] gx_r;
  logic [ctf_pkg::IDX_W-1:0]        iter_r;
  logic [1:0]                       fstep_r;
  logic signed [ctf_pkg::ANG_W-1:0] angle_r, angle_new;
  logic signed [ctf_pkg::ACC_W-1:0] prod_r, sum_r, rnd;
  logic signed [ctf_pkg::ANG_W-1:0] mul_a;
  logic signed [ctf_pkg::KC_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]          mul_p;
  logic signed [ctf_pkg::ACC_W-31:0] shifted;
  logic                             out_valid_r;
  logic signed [ctf_pkg::ANG_W-1:0] out_fused_r;
  logic signed [ctf_pkg::Z_W-1:0]   out_accel_r;
  logic                             out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctf_pkg::ST_IDLE: if (q_valid) state_nxt = q_req.bypass ? ctf_pkg::ST_FUSE
                                                               : ctf_pkg::ST_ROT;
      ctf_pkg::ST_ROT:  if (iter_r == ITER_LAST) state_nxt = ctf_pkg::ST_FUSE;
      ctf_pkg::ST_FUSE: if (fstep_r == 2'd3) state_nxt = ctf_pkg::ST_DONE;
      ctf_pkg::ST_DONE: if (out_free) state_nxt = ctf_pkg::ST_IDLE;
      default:          state_nxt = ctf_pkg::ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ctf_pkg::ST_IDLE: ctl.pop    = q_valid;
      ctf_pkg::ST_ROT:  ctl.rot    = 1'b1;
      ctf_pkg::ST_FUSE: ctl.fuse   = 1'b1;
      ctf_pkg::ST_DONE: ctl.finish = out_free;
      default:          ctl = '0;
    endcase
  end

  assign q_pop = ctl.pop;

  // CORDIC micro-rotation terms
  assign dx     = y_r >>> iter_r;
  assign dy     = x_r >>> iter_r;
  assign atan_s = $signed({{(ctf_pkg::Z_W-ctf_pkg::ATAN_W){1'b0}}, ctf_pkg::atan_lut(iter_r)});

  // Accelerometer angle after offset
  assign acc_ang = z_r - {{(ctf_pkg::Z_W-ctf_pkg::OFS_W){tilt_offset[ctf_pkg::OFS_W-1]}},
                          tilt_offset};

  // Shared multiplier: one product per fusion step
  always_comb begin
    mul_a = angle_r;
    mul_b = ctf_pkg::K_KEEP;
    case (fstep_r)
      2'd1: begin
        mul_a = {{(ctf_pkg::ANG_W-ctf_pkg::RAW_W){gx_r[ctf_pkg::RAW_W-1]}}, gx_r};
        mul_b = ctf_pkg::K_GYRO;
      end
      2'd2: begin
        mul_a = {{(ctf_pkg::ANG_W-ctf_pkg::Z_W){acc_ang[ctf_pkg::Z_W-1]}}, acc_ang};
        mul_b = ctf_pkg::K_ACC;
      end
      default: begin
        mul_a = angle_r;
        mul_b = ctf_pkg::K_KEEP;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Round half up from Q30, saturate to 32 bits
  always_comb begin
    rnd     = sum_r + ctf_pkg::HALF_Q30;
    shifted = rnd[ctf_pkg::ACC_W-1:30];
    if (shifted > $signed({{(ctf_pkg::ACC_W-30-ctf_pkg::ANG_W){1'b0}},
                           1'b0, {(ctf_pkg::ANG_W-1){1'b1}}})) begin
      angle_new = {1'b0, {(ctf_pkg::ANG_W-1){1'b1}}};
    end else if (shifted < $signed({{(ctf_pkg::ACC_W-30-ctf_pkg::ANG_W){1'b1}},
                                    1'b1, {(ctf_pkg::ANG_W-1){1'b0}}})) begin
      angle_new = {1'b1, {(ctf_pkg::ANG_W-1){1'b0}}};
    end else begin
      angle_new = shifted[ctf_pkg::ANG_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctf_pkg::ST_IDLE;
      iter_r      <= '0;
      fstep_r     <= '0;
      angle_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= ctl.rot ? iter_r + 1'b1 : '0;
      fstep_r <= ctl.fuse ? fstep_r + 1'b1 : '0;
      if (ctl.finish) begin
        angle_r     <= angle_new;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      x_r  <= q_req.x;
      y_r  <= q_req.y;
      z_r  <= q_req.z;
      gx_r <= q_req.gx;
    end else if (ctl.rot) begin
      if (!y_r[ctf_pkg::XY_W-1]) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_s;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_s;
      end
    end
    if (ctl.fuse) begin
      prod_r <= mul_p[ctf_pkg::ACC_W-1:0];
      sum_r  <= (fstep_r == 2'd0) ? '0 : sum_r + prod_r;
    end
    if (ctl.finish) begin
      out_fused_r <= angle_new;
      out_accel_r <= acc_ang;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fused_angle = out_fused_r;
  assign out_accel_angle = out_accel_r;

  // Stored angle moves only when a result is loaded
  a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(ctl.finish)) |-> $stable(angle_r))
    else $error("stored angle changed without a result");

  // A result is never loaded over one still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten");

  // Iteration count stays within the table
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctf_pkg::ST_ROT) |-> (iter_r <= ITER_LAST))
    else $error("CORDIC iteration count out of range");

endmodule

// ===== rtl/core/complementary_tilt_filter_top.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_acc_y, in_acc_z, in_gyro_x (s16)
// out      out_valid / out_stall  out_fused_angle (s32), out_accel_angle (s27)
// cfg      cfg_we                 cfg_tilt_offset (s25)
//
// In the back end a request passes through the single iterative CORDIC unit and then
// the four-step shared fusion multiplier; a sample on the x axis skips the CORDIC.
// Up to two classified requests wait in the front queue; in_stall rises when it is full.
// out_stall holds the result register and, once the next result is ready, the back end.
// Synchronous active-low reset clears the stored angle and the tilt offset.
module complementary_tilt_filter_top #(
  parameter int CORDIC_STEPS = ctf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ctf_pkg::RAW_W-1:0]   in_acc_y,
  input  logic signed [ctf_pkg::RAW_W-1:0]   in_acc_z,
  input  logic signed [ctf_pkg::RAW_W-1:0]   in_gyro_x,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [ctf_pkg::ANG_W-1:0]   out_fused_angle,
  output logic signed [ctf_pkg::Z_W-1:0]     out_accel_angle,
  input  logic                               cfg_we,
  input  logic signed [ctf_pkg::OFS_W-1:0]   cfg_tilt_offset
);

  logic                              q_valid;
  logic                              q_pop;
  ctf_pkg::ctf_req_t                 q_req;
  logic signed [ctf_pkg::OFS_W-1:0]  tilt_offset_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_offset_r <= '0;
    end else if (cfg_we) begin
      tilt_offset_r <= cfg_tilt_offset;
    end
  end

  ctf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_acc_y  (in_acc_y),
    .in_acc_z  (in_acc_z),
    .in_gyro_x (in_gyro_x),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop)
  );

  ctf_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_req           (q_req),
    .q_pop           (q_pop),
    .tilt_offset     (tilt_offset_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fused_angle (out_fused_angle),
    .out_accel_angle (out_accel_angle)
  );

endmodule
